// ===== hw/rtl/fvma_pkg.sv =====
`default_nettype none

package fvma_pkg;

  localparam int IN_W         = 16;
  localparam int GUARD_BITS   = 24;
  localparam int XY_W         = 43;
  localparam int Z_W          = 34;
  localparam int ROOT_W       = 33;
  localparam int REM_W        = 32;
  localparam int SQ_W         = 31;
  localparam int ATAN_ENTRIES = 24;
  localparam int SQRT_STEPS   = 16;
  localparam int MAG_W        = 16;
  localparam int CODE_W       = 8;

  localparam logic [CODE_W-1:0] CODE_ZERO_ANGLE = 8'd127;
  localparam logic [CODE_W-1:0] CODE_MAX        = 8'd254;
  localparam logic [CODE_W-1:0] CODE_MIN        = 8'd0;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [REM_W-1:0]       rem;
    logic [ROOT_W-1:0]      root;
    logic                   on_axis;
    logic [CODE_W-1:0]      axis_code;
  } lane_t;

  // atan(2^-i) with pi = 2^31
  function automatic logic [31:0] atan_entry(input int idx);
    logic [31:0] v;
    case (idx)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051E;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2F;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2FA;
      15:      v = 32'h0000517D;
      16:      v = 32'h000028BE;
      17:      v = 32'h0000145F;
      18:      v = 32'h00000A30;
      19:      v = 32'h00000518;
      20:      v = 32'h0000028C;
      21:      v = 32'h00000146;
      22:      v = 32'h000000A3;
      23:      v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fvma_cell.sv =====
`default_nettype none

module fvma_cell #(
  parameter int IDX       = 0,
  parameter bit CORDIC_EN = 1'b1,
  parameter bit SQRT_EN   = 1'b1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            vld_in,
  input  wire fvma_pkg::lane_t lane_in,
  output logic                 vld_out,
  output fvma_pkg::lane_t      lane_out
);

  localparam int SH = SQRT_EN ? 2 * (fvma_pkg::SQRT_STEPS - 1 - IDX) : 0;
  localparam logic [fvma_pkg::ROOT_W-1:0] SQ_BIT = fvma_pkg::ROOT_W'(1) << SH;
  localparam logic [fvma_pkg::Z_W-1:0] ATAN =
    {{(fvma_pkg::Z_W-32){1'b0}}, fvma_pkg::atan_entry(IDX)};

  logic signed [fvma_pkg::XY_W-1:0] x, y, dx, dy;
  logic signed [fvma_pkg::Z_W-1:0]  z;
  logic [fvma_pkg::ROOT_W-1:0]      trial;
  fvma_pkg::lane_t                  lane_next;

  always_comb begin
    x = lane_in.x;
    y = lane_in.y;
    z = lane_in.z;
    dx = y >>> IDX;
    dy = x >>> IDX;
    trial = lane_in.root + SQ_BIT;
    lane_next = lane_in;
    if (CORDIC_EN) begin
      if (!y[fvma_pkg::XY_W-1]) begin
        lane_next.x = x + dx;
        lane_next.y = y - dy;
        lane_next.z = z + $signed(ATAN);
      end else begin
        lane_next.x = x - dx;
        lane_next.y = y + dy;
        lane_next.z = z - $signed(ATAN);
      end
    end
    if (SQRT_EN) begin
      if ({1'b0, lane_in.rem} >= trial) begin
        lane_next.rem  = lane_in.rem - trial[fvma_pkg::REM_W-1:0];
        lane_next.root = (lane_in.root >> 1) + SQ_BIT;
      end else begin
        lane_next.root = lane_in.root >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    lane_out <= lane_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/flow_vector_magnitude_angle.sv =====
// path: an accepted beat passes the front stage register, the sum-of-squares
//   register, the row of cells and the output register, then done is high
// throughput: one beat per cycle while busy is low, set by the row of cordic/square-root cells
// reset: synchronous rst empties the pipeline; busy is high during reset and
//   the first cycle after it, and low from then on
// the receiver cannot stall: each result stands for exactly one cycle
`default_nettype none

module flow_vector_magnitude_angle #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic signed [fvma_pkg::IN_W-1:0] flow_x,
  input  wire logic signed [fvma_pkg::IN_W-1:0] flow_y,
  output logic                                 done,
  output logic [fvma_pkg::MAG_W-1:0]           magnitude,
  output logic [fvma_pkg::CODE_W-1:0]          angle_code
);

  localparam int STEPS = (CORDIC_ITERATIONS > fvma_pkg::ATAN_ENTRIES) ?
                         fvma_pkg::ATAN_ENTRIES : CORDIC_ITERATIONS;
  localparam int CELLS = (STEPS > fvma_pkg::SQRT_STEPS) ? STEPS : fvma_pkg::SQRT_STEPS;
  localparam int W_W   = fvma_pkg::Z_W + 1;
  localparam int NUM_W = W_W + 8;

  logic accept;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // front stage: operand conditioning and squares
  logic                           a_vld;
  fvma_pkg::lane_t                a_lane;
  logic [fvma_pkg::SQ_W-1:0]      a_sqx, a_sqy;
  logic signed [fvma_pkg::IN_W:0] x0, y0;
  logic signed [fvma_pkg::Z_W-1:0] z0;
  logic signed [2*fvma_pkg::IN_W-1:0] px, py;
  fvma_pkg::lane_t                a_next;

  always_comb begin
    px = (2*fvma_pkg::IN_W)'(flow_x) * (2*fvma_pkg::IN_W)'(flow_x);
    py = (2*fvma_pkg::IN_W)'(flow_y) * (2*fvma_pkg::IN_W)'(flow_y);
    if (flow_y[fvma_pkg::IN_W-1]) begin
      x0 = -{flow_y[fvma_pkg::IN_W-1], flow_y};
      y0 = -{flow_x[fvma_pkg::IN_W-1], flow_x};
      z0 = flow_x[fvma_pkg::IN_W-1] ? -(fvma_pkg::Z_W'(1) <<< 31) :
                                       (fvma_pkg::Z_W'(1) <<< 31);
    end else begin
      x0 = {flow_y[fvma_pkg::IN_W-1], flow_y};
      y0 = {flow_x[fvma_pkg::IN_W-1], flow_x};
      z0 = '0;
    end
    a_next.x = fvma_pkg::XY_W'(x0) <<< fvma_pkg::GUARD_BITS;
    a_next.y = fvma_pkg::XY_W'(y0) <<< fvma_pkg::GUARD_BITS;
    a_next.z = z0;
    a_next.rem = '0;
    a_next.root = '0;
    a_next.on_axis = (flow_x == '0);
    a_next.axis_code = flow_y[fvma_pkg::IN_W-1] ? fvma_pkg::CODE_MAX :
                                                  fvma_pkg::CODE_ZERO_ANGLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    a_lane <= a_next;
    a_sqx  <= px[fvma_pkg::SQ_W-1:0];
    a_sqy  <= py[fvma_pkg::SQ_W-1:0];
  end

  // sum of squares
  logic            vld [CELLS+1];
  fvma_pkg::lane_t lane [CELLS+1];
  fvma_pkg::lane_t lane0_next;

  always_comb begin
    lane0_next      = a_lane;
    lane0_next.rem  = fvma_pkg::REM_W'(a_sqx) + fvma_pkg::REM_W'(a_sqy);
    lane0_next.root = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    lane[0] <= lane0_next;
  end

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    fvma_cell #(
      .IDX       (k),
      .CORDIC_EN (k < STEPS),
      .SQRT_EN   (k < fvma_pkg::SQRT_STEPS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .vld_in   (vld[k]),
      .lane_in  (lane[k]),
      .vld_out  (vld[k+1]),
      .lane_out (lane[k+1])
    );
  end

  // rounding and phase code
  fvma_pkg::lane_t                   last;
  logic                              round_up;
  logic [fvma_pkg::MAG_W-1:0]        magnitude_next;
  logic signed [W_W-1:0]             w;
  logic signed [NUM_W-1:0]           num;
  logic [NUM_W-32:0]                 q;
  logic [fvma_pkg::CODE_W-1:0]       angle_code_next;

  always_comb begin
    last = lane[CELLS];
    round_up = ({1'b0, last.rem} > last.root);
    magnitude_next = last.root[fvma_pkg::MAG_W-1:0] + fvma_pkg::MAG_W'(round_up);
    w = W_W'(last.z) + (W_W'(1) <<< 31);
    num = (NUM_W'(w) <<< 7) - NUM_W'(w);
    q = num[NUM_W-1:31];
    if (last.on_axis) begin
      angle_code_next = last.axis_code;
    end else if (num[NUM_W-1]) begin
      angle_code_next = fvma_pkg::CODE_MIN;
    end else if (q > (NUM_W-31)'(fvma_pkg::CODE_MAX)) begin
      angle_code_next = fvma_pkg::CODE_MAX;
    end else begin
      angle_code_next = q[fvma_pkg::CODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[CELLS];
    end
  end

  always_ff @(posedge clk) begin
    magnitude  <= magnitude_next;
    angle_code <= angle_code_next;
  end

endmodule

`default_nettype wire

// ===== tb/flow_vector_magnitude_angle_tb.sv =====
`timescale 1ns / 100ps

module flow_vector_magnitude_angle_tb;

  localparam int ITERS       = 16;
  localparam int STEPS_USED  = (ITERS > fvma_pkg::ATAN_ENTRIES) ? fvma_pkg::ATAN_ENTRIES : ITERS;
  localparam int LATENCY     = ((ITERS > 16) ? ITERS : 16) + 3;
  localparam int STALL_LIMIT = 2000;
  localparam longint HALF_TURN = 64'sh80000000;

  typedef struct {
    logic signed [fvma_pkg::IN_W-1:0] fx;
    logic signed [fvma_pkg::IN_W-1:0] fy;
    logic [fvma_pkg::MAG_W-1:0]       mag;
    logic [fvma_pkg::CODE_W-1:0]      code;
  } polar_expect_t;

  // atan(2^-i) in units where pi = 2^31
  longint arctan_step [fvma_pkg::ATAN_ENTRIES] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
    64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [fvma_pkg::IN_W-1:0] flow_x = '0;
  logic signed [fvma_pkg::IN_W-1:0] flow_y = '0;
  logic busy;
  logic done;
  logic [fvma_pkg::MAG_W-1:0] magnitude;
  logic [fvma_pkg::CODE_W-1:0] angle_code;

  polar_expect_t pending_polar[$];
  polar_expect_t oldest;
  int vectors_issued = 0;
  int results_seen = 0;
  int failures = 0;
  int stall_cycles = 0;
  int axis_vectors = 0;
  int left_half_vectors = 0;
  int code_edge_hits = 0;

  always #6 clk = ~clk;

  flow_vector_magnitude_angle #(
    .CORDIC_ITERATIONS(ITERS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .flow_x(flow_x),
    .flow_y(flow_y),
    .done(done),
    .magnitude(magnitude),
    .angle_code(angle_code)
  );

  function automatic logic [fvma_pkg::MAG_W-1:0] vector_length(
      logic signed [fvma_pkg::IN_W-1:0] fx, logic signed [fvma_pkg::IN_W-1:0] fy);
    longint unsigned sq, rem, root, bitv;
    sq = longint'(fx) * longint'(fx) + longint'(fy) * longint'(fy);
    rem = sq;
    root = 0;
    bitv = 64'h1 << 32;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    if (sq - root * root > root) root = root + 1;
    return root[fvma_pkg::MAG_W-1:0];
  endfunction

  // atan2(ordinate, abscissa) through the same cordic rotation sequence
  function automatic logic [fvma_pkg::CODE_W-1:0] phase_byte(
      logic signed [fvma_pkg::IN_W-1:0] ordinate,
      logic signed [fvma_pkg::IN_W-1:0] abscissa);
    longint x, y, z, dx, dy, num;
    if (ordinate == 0) begin
      return (abscissa < 0) ? fvma_pkg::CODE_MAX : fvma_pkg::CODE_ZERO_ANGLE;
    end
    if (abscissa < 0) begin
      x = -longint'(abscissa);
      y = -longint'(ordinate);
      z = (ordinate >= 0) ? HALF_TURN : -HALF_TURN;
    end else begin
      x = longint'(abscissa);
      y = longint'(ordinate);
      z = 0;
    end
    x = x * (64'sd1 <<< fvma_pkg::GUARD_BITS);
    y = y * (64'sd1 <<< fvma_pkg::GUARD_BITS);
    for (int i = 0; i < STEPS_USED; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + arctan_step[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - arctan_step[i];
      end
    end
    num = z * 127 + 127 * HALF_TURN;
    if (num < 0) return fvma_pkg::CODE_MIN;
    num = num >>> 31;
    if (num > longint'(fvma_pkg::CODE_MAX)) return fvma_pkg::CODE_MAX;
    return num[fvma_pkg::CODE_W-1:0];
  endfunction

  // prediction on each accepted beat, comparison on each result beat
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (pending_polar.size() == 0) begin
          failures++;
          $display("%0t: result with nothing pending: magnitude %0d angle_code %0d",
                   $time, magnitude, angle_code);
        end else begin
          oldest = pending_polar.pop_front();
          results_seen++;
          if (magnitude !== oldest.mag) begin
            failures++;
            $display("%0t: magnitude for (%0d,%0d): expected %0d, actual %0d",
                     $time, oldest.fx, oldest.fy, oldest.mag, magnitude);
          end
          if (angle_code !== oldest.code) begin
            failures++;
            $display("%0t: angle_code for (%0d,%0d): expected %0d, actual %0d",
                     $time, oldest.fx, oldest.fy, oldest.code, angle_code);
          end
        end
      end
      if (start && !busy) begin
        oldest.fx = flow_x;
        oldest.fy = flow_y;
        oldest.mag = vector_length(flow_x, flow_y);
        oldest.code = (flow_x == 0 && flow_y == 0) ? fvma_pkg::CODE_ZERO_ANGLE
                                                   : phase_byte(flow_x, flow_y);
        pending_polar.push_back(oldest);
        if (flow_x == 0 || flow_y == 0) axis_vectors++;
        if (flow_y < 0) left_half_vectors++;
        if (oldest.code == fvma_pkg::CODE_MIN || oldest.code == fvma_pkg::CODE_MAX) begin
          code_edge_hits++;
        end
      end
      if (done || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // idles each cycle with the given chance, then holds one beat until taken
  task automatic send_vector(input logic signed [fvma_pkg::IN_W-1:0] fx,
                             input logic signed [fvma_pkg::IN_W-1:0] fy,
                             input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    flow_x <= fx;
    flow_y <= fy;
    do @(posedge clk); while (busy);
    vectors_issued++;
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (results_seen != vectors_issued) @(posedge clk);
  endtask

  task automatic pick_vector(output logic signed [fvma_pkg::IN_W-1:0] fx,
                             output logic signed [fvma_pkg::IN_W-1:0] fy);
    case ($urandom_range(0, 9))
      4: begin
        fx = $urandom_range(0, 511) - 256;
        fy = $urandom_range(0, 511) - 256;
      end
      5: begin
        fx = $urandom;
        fy = $urandom;
        if ($urandom_range(0, 1)) fx = '0;
        else fy = '0;
      end
      6: begin
        fx = ($urandom_range(0, 2) == 0) ? $urandom : ($urandom_range(0, 1) ? 32767 : -32768);
        fy = ($urandom_range(0, 2) == 0) ? $urandom : ($urandom_range(0, 1) ? 32767 : -32768);
      end
      7: begin
        fx = $urandom;
        fy = $urandom_range(0, 1) ? fx : -fx;
      end
      8: begin
        // close to the negative abscissa, where the code saturates
        fx = $urandom_range(0, 6) - 3;
        fy = -$signed($urandom_range(1, 32768));
      end
      default: begin
        fx = $urandom;
        fy = $urandom;
      end
    endcase
  endtask

  task automatic test_zero_and_axes();
    send_vector(0, 0, 30);
    send_vector(0, 1, 30);
    send_vector(0, -1, 30);
    send_vector(0, 256, 30);
    send_vector(0, -256, 30);
    send_vector(0, 32767, 30);
    send_vector(0, -32768, 30);
    send_vector(256, 0, 30);
    send_vector(-256, 0, 30);
    send_vector(32767, 0, 30);
    send_vector(-32768, 0, 30);
  endtask

  task automatic test_extremes();
    send_vector(32767, 32767, 30);
    send_vector(-32768, -32768, 30);
    send_vector(32767, -32768, 30);
    send_vector(-32768, 32767, 30);
    send_vector(1, 1, 30);
    send_vector(-1, -1, 30);
    send_vector(181, 181, 30);
  endtask

  task automatic test_near_branch_cut();
    send_vector(1, -32768, 30);
    send_vector(-1, -32768, 30);
    send_vector(1, -1, 30);
    send_vector(-32768, 1, 30);
    wait_for_results();
  endtask

  task automatic test_random_stream(input int count, input int idle_pct, input int hold_at);
    logic signed [fvma_pkg::IN_W-1:0] fx, fy;
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) wait_for_results();
      pick_vector(fx, fy);
      send_vector(fx, fy, idle_pct);
    end
    wait_for_results();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_zero_and_axes();
    test_extremes();
    test_near_branch_cut();
    test_random_stream(245, 38, 100);
    test_random_stream(245, 64, 120);
    test_random_stream(245, 0, 60);
    wait_for_results();
    repeat (LATENCY + 8) @(posedge clk);
    $display("covered %0d vectors (%0d on an axis, %0d with negative second component)",
             vectors_issued, axis_vectors, left_half_vectors);
    $display("compared %0d results, %0d at a code limit, under three idle patterns",
             results_seen, code_edge_hits);
    if (failures == 0 && pending_polar.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/fvma_pkg.sv
hw/rtl/fvma_cell.sv
hw/rtl/flow_vector_magnitude_angle.sv
tb/flow_vector_magnitude_angle_tb.sv
